### src/wsd_pkg.sv
// shared types and constants for the websocket deframer and unmasker
// no dependencies; used by every module under src
`default_nettype none

package wsd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W = 16;
    localparam int unsigned KEY_W = 32;

    // seven-bit length codes that select the extended length forms
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef enum logic [4:0] {
        PH_HDR0    = 5'b00001,
        PH_HDR1    = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_MASK    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_end;
        logic              frame_empty;
        logic              too_long_error;
    } result_t;

    // pipeline control between the input, parse and output stages
    typedef struct packed {
        logic advance;
        logic out_space;
    } pipe_ctrl_t;

    // key byte for a payload index, first key byte in the top bits
    function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] key,
                                                   input logic [1:0] idx);
        logic [BYTE_W-1:0] kb;
        case (idx)
            2'd0:    kb = key[31:24];
            2'd1:    kb = key[23:16];
            2'd2:    kb = key[15:8];
            default: kb = key[7:0];
        endcase
        return kb;
    endfunction

endpackage

`default_nettype wire

### src/wsd_in_reg.sv
// input register stage of the websocket deframer
// depends on wsd_pkg for the pipeline control struct
`default_nettype none

module wsd_in_reg (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [wsd_pkg::BYTE_W-1:0] s_tdata,
    input  wire wsd_pkg::pipe_ctrl_t     ctrl,
    output logic                         in_valid,
    output logic [wsd_pkg::BYTE_W-1:0]   in_byte
);

    logic                       valid_reg;
    logic [wsd_pkg::BYTE_W-1:0] byte_reg;

    // free slot when empty or when the held byte moves on this cycle
    assign s_tready = !valid_reg || ctrl.advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctrl.advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

`default_nettype wire

### src/wsd_parse.sv
// frame parser state and unmasking logic of the websocket deframer
// depends on wsd_pkg for phase codes, result struct and key byte select
`default_nettype none

module wsd_parse (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [wsd_pkg::BYTE_W-1:0] rx_byte,
    output logic                            res_valid,
    output wsd_pkg::result_t                res
);

    wsd_pkg::phase_t           phase_reg, phase_next;
    logic                      masked_reg, masked_next;
    logic [wsd_pkg::LEN_W-1:0] rem_reg, rem_next;
    logic [wsd_pkg::KEY_W-1:0] key_reg, key_next;
    logic [1:0]                idx_reg, idx_next;
    logic [1:0]                sub_reg, sub_next;
    logic                      closed_reg, closed_next;

    always_comb
    begin
        logic                       lk_req;
        logic                       lk_masked;
        logic [wsd_pkg::LEN_W-1:0]  lk_rem;
        logic [wsd_pkg::LEN_W-1:0]  rem_dec;
        logic [wsd_pkg::BYTE_W-1:0] kb;

        phase_next  = phase_reg;
        masked_next = masked_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        sub_next    = sub_reg;
        closed_next = closed_reg;
        res_valid   = 1'b0;
        res         = '0;
        lk_req      = 1'b0;
        lk_masked   = masked_reg;
        lk_rem      = rem_reg;
        rem_dec     = rem_reg - wsd_pkg::LEN_W'(1);
        kb          = masked_reg ? wsd_pkg::key_byte(key_reg, idx_reg) : '0;

        if (!closed_reg)
        begin
            case (phase_reg)
                wsd_pkg::PH_HDR1:
                begin
                    masked_next = rx_byte[7];
                    if (rx_byte[6:0] == wsd_pkg::LEN_EXT64)
                    begin
                        closed_next        = 1'b1;
                        phase_next         = wsd_pkg::PH_HDR0;
                        res_valid          = 1'b1;
                        res.too_long_error = 1'b1;
                    end
                    else if (rx_byte[6:0] == wsd_pkg::LEN_EXT16)
                    begin
                        phase_next = wsd_pkg::PH_EXTLEN;
                        sub_next   = 2'd0;
                        rem_next   = '0;
                    end
                    else
                    begin
                        lk_req    = 1'b1;
                        lk_masked = rx_byte[7];
                        lk_rem    = {9'd0, rx_byte[6:0]};
                    end
                end
                wsd_pkg::PH_EXTLEN:
                begin
                    if (sub_reg == 2'd0)
                    begin
                        rem_next = {rx_byte, 8'd0};
                        sub_next = 2'd1;
                    end
                    else
                    begin
                        sub_next = 2'd0;
                        lk_req   = 1'b1;
                        lk_rem   = rem_reg | {8'd0, rx_byte};
                    end
                end
                wsd_pkg::PH_MASK:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    if (sub_reg != 2'd3)
                    begin
                        sub_next = sub_reg + 2'd1;
                    end
                    else
                    begin
                        sub_next = 2'd0;
                        if (rem_reg == '0)
                        begin
                            phase_next      = wsd_pkg::PH_HDR0;
                            res_valid       = 1'b1;
                            res.frame_end   = 1'b1;
                            res.frame_empty = 1'b1;
                        end
                        else
                        begin
                            phase_next = wsd_pkg::PH_PAYLOAD;
                            idx_next   = 2'd0;
                        end
                    end
                end
                wsd_pkg::PH_PAYLOAD:
                begin
                    idx_next         = idx_reg + 2'd1;
                    rem_next         = rem_dec;
                    res_valid        = 1'b1;
                    res.payload_byte = rx_byte ^ kb;
                    if (rem_dec == '0)
                    begin
                        phase_next    = wsd_pkg::PH_HDR0;
                        res.frame_end = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = wsd_pkg::PH_HDR1;
                end
            endcase

            // header complete: key bytes next, payload next, or an empty frame
            if (lk_req)
            begin
                rem_next = lk_rem;
                if (lk_masked)
                begin
                    phase_next = wsd_pkg::PH_MASK;
                    sub_next   = 2'd0;
                end
                else if (lk_rem == '0)
                begin
                    phase_next      = wsd_pkg::PH_HDR0;
                    res_valid       = 1'b1;
                    res.frame_end   = 1'b1;
                    res.frame_empty = 1'b1;
                end
                else
                begin
                    phase_next = wsd_pkg::PH_PAYLOAD;
                    idx_next   = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wsd_pkg::PH_HDR0;
            masked_reg <= 1'b0;
            rem_reg    <= '0;
            key_reg    <= '0;
            idx_reg    <= 2'd0;
            sub_reg    <= 2'd0;
            closed_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            masked_reg <= masked_next;
            rem_reg    <= rem_next;
            key_reg    <= key_next;
            idx_reg    <= idx_next;
            sub_reg    <= sub_next;
            closed_reg <= closed_next;
        end
    end

    // a closed connection never reopens without reset
    assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("closed flag dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |-> !res_valid)
        else $error("result produced after close");

    // payload phase is only entered with bytes still to come
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wsd_pkg::PH_PAYLOAD) |-> (rem_reg != '0))
        else $error("payload phase with zero remaining");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.frame_empty) |-> (res.frame_end && res.payload_byte == '0))
        else $error("malformed empty frame marker");

endmodule

`default_nettype wire

### src/wsd_out_reg.sv
// result register stage of the websocket deframer
// depends on wsd_pkg for the result struct and pipeline control struct
`default_nettype none

module wsd_out_reg (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  res_valid,
    input  wire wsd_pkg::result_t      res,
    output wsd_pkg::pipe_ctrl_t        ctrl,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [wsd_pkg::BYTE_W-1:0] m_tdata,
    output logic                       m_tlast,
    output logic [1:0]                 m_tuser
);

    logic             valid_reg;
    wsd_pkg::result_t res_reg;

    // the held result leaves or the register is empty: the next byte can step
    assign ctrl.out_space = !valid_reg || m_tready;
    assign ctrl.advance   = in_valid && ctrl.out_space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.out_space)
        begin
            valid_reg <= ctrl.advance && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.payload_byte;
    assign m_tlast  = res_reg.frame_end;
    assign m_tuser  = {res_reg.too_long_error, res_reg.frame_empty};

endmodule

`default_nettype wire

### src/websocket_frame_deframer_unmask.sv
// Receive-side websocket deframer: takes the stream one byte per transfer, strips the
// header (first byte skipped, mask bit and length, optional 16-bit extended length,
// optional 4-byte key) and returns each payload byte XORed with the key, with tlast on
// the last byte of a frame. A zero-length frame gives one transfer with tuser[0] set and
// tlast set. A 64-bit length code gives one transfer with tuser[1] set, after which all
// input is taken and dropped until reset. One byte is taken every cycle unless m_tready
// holds the output back; the state update of the parser between the input register and
// the result register is the only loop, and each byte's result goes through the input and
// result registers on its way to the master side. No clearing pass after reset.
// depends on wsd_pkg, wsd_in_reg, wsd_parse and wsd_out_reg
`default_nettype none

module websocket_frame_deframer_unmask (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] payload_byte
    output logic            m_tlast,   // frame_end
    output logic [1:0]      m_tuser    // [0] frame_empty, [1] too_long_error
);

    wsd_pkg::pipe_ctrl_t        ctrl;
    logic                       in_valid;
    logic [wsd_pkg::BYTE_W-1:0] in_byte;
    logic                       res_valid;
    wsd_pkg::result_t           res;

    wsd_in_reg u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .ctrl     (ctrl),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    wsd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (ctrl.advance),
        .rx_byte   (in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .res_valid (res_valid),
        .res       (res),
        .ctrl      (ctrl),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
